// File: src/tsc_pkg.sv
// Shared types, character codes and status codes of the token spelling checker.
`timescale 1ns / 1ps

package tsc_pkg;

   // Token kinds as they arrive with the first character.
   localparam logic [1:0] KIND_NUMBER  = 2'd0;
   localparam logic [1:0] KIND_WORD    = 2'd1;
   localparam logic [1:0] KIND_SIGN    = 2'd2;
   localparam logic [1:0] KIND_UNKNOWN = 2'd3;

   // Characters with a rule of their own.
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_POINT      = 8'h2E;
   localparam logic [7:0] CH_ZERO       = 8'h30;

   // Status codes of a finished token.
   localparam logic [3:0] ST_OK           = 4'd0;
   localparam logic [3:0] ST_SIGN_LENGTH  = 4'd1;
   localparam logic [3:0] ST_SIGN_SYMBOL  = 4'd2;
   localparam logic [3:0] ST_EMPTY        = 4'd3;
   localparam logic [3:0] ST_WORD_START   = 4'd4;
   localparam logic [3:0] ST_WORD_SYMBOL  = 4'd5;
   localparam logic [3:0] ST_EDGE_POINT   = 4'd6;
   localparam logic [3:0] ST_LEADING_ZERO = 4'd7;
   localparam logic [3:0] ST_NUM_SYMBOL   = 4'd8;
   localparam logic [3:0] ST_POINTS       = 4'd9;

   // One request word as held in the input register.
   typedef struct packed {
      logic [1:0] token_kind;
      logic [7:0] char_code;
      logic       last_char;
      logic       empty_token;
   } req_word_type;

   // State carried from one character of a token to the next.
   typedef struct packed {
      logic [1:0] char_position;
      logic [1:0] kind_held;
      logic       first_was_point;
      logic       first_was_zero;
      logic       leading_zero_fault;
      logic       point_seen;
      logic [3:0] earliest_fault;
   } token_state_type;

   localparam token_state_type TOKEN_STATE_CLEAR = '0;

endpackage

// File: src/tsc_if.sv
// Handshake channels of the token spelling checker: request and response.
`timescale 1ns / 1ps

interface tsc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] token_kind;
   logic [7:0] char_code;
   logic       last_char;
   logic       empty_token;

   modport source (output valid, output token_kind, output char_code,
                   output last_char, output empty_token, input ready);
   modport sink   (input valid, input token_kind, input char_code,
                   input last_char, input empty_token, output ready);
endinterface

interface tsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] status;

   modport source (output valid, output status, input ready);
   modport sink   (input valid, input status, output ready);
endinterface

// File: src/tsc_core.sv
// Per-character classification, token state update and status decision.
`timescale 1ns / 1ps

module tsc_core (
   input  tsc_pkg::req_word_type    word,
   input  tsc_pkg::token_state_type state,
   output tsc_pkg::token_state_type state_in,
   output logic                     has_result,
   output logic [3:0]               status
);
   import tsc_pkg::*;

   logic       is_point;
   logic       is_zero;
   logic       is_digit;
   logic       is_alpha;
   logic       is_word_part;
   logic       first_pos;
   logic [1:0] kind;
   logic       fwp;
   logic       fwz;
   logic       lz;
   logic       ps;
   logic [3:0] fault;
   logic [3:0] last_status;
   token_state_type upd;

   // Character classes; bytes at or above 128 fall in no class.
   always_comb begin
      is_point     = (word.char_code == CH_POINT);
      is_zero      = (word.char_code == CH_ZERO);
      is_digit     = (word.char_code >= 8'h30) && (word.char_code <= 8'h39);
      is_alpha     = ((word.char_code >= 8'h41) && (word.char_code <= 8'h5A)) ||
                     ((word.char_code >= 8'h61) && (word.char_code <= 8'h7A));
      is_word_part = is_alpha || (word.char_code == CH_UNDERSCORE);
   end

   // Values that the first character fixes for the whole token.
   always_comb begin
      first_pos = (state.char_position == 2'd0);
      kind      = first_pos ? word.token_kind : state.kind_held;
      fwp       = first_pos ? is_point : state.first_was_point;
      fwz       = first_pos ? is_zero  : state.first_was_zero;
      lz        = state.leading_zero_fault |
                  ((state.char_position == 2'd1) && fwz && !is_point);
   end

   // Earliest fault inside the token, by kind.
   always_comb begin
      fault = state.earliest_fault;
      ps    = state.point_seen;
      unique case (kind)
         KIND_NUMBER: begin
            if (fault == ST_OK) begin
               if (!is_digit && !is_point) begin
                  fault = ST_NUM_SYMBOL;
               end else if (is_point && ps) begin
                  fault = ST_POINTS;
               end
            end
            if (is_point) begin
               ps = 1'b1;
            end
         end
         KIND_WORD: begin
            if (first_pos) begin
               if (!is_word_part) begin
                  fault = ST_WORD_START;
               end
            end else if (fault == ST_OK && !(is_digit || is_word_part)) begin
               fault = ST_WORD_SYMBOL;
            end
         end
         KIND_SIGN: begin
            if (first_pos && (is_digit || is_word_part || is_point)) begin
               fault = ST_SIGN_SYMBOL;
            end
         end
         default: begin
         end
      endcase
   end

   // Status at the last character of a token.
   always_comb begin
      unique case (kind)
         KIND_NUMBER: begin
            if (fwp || is_point) begin
               last_status = ST_EDGE_POINT;
            end else if (lz) begin
               last_status = ST_LEADING_ZERO;
            end else begin
               last_status = fault;
            end
         end
         KIND_WORD: last_status = fault;
         KIND_SIGN: last_status = first_pos ? fault : ST_SIGN_LENGTH;
         default:   last_status = ST_EMPTY;
      endcase
   end

   // Next token state; an empty token or a last character closes the token.
   always_comb begin
      upd.char_position      = (state.char_position == 2'd2) ? 2'd2 :
                               state.char_position + 2'd1;
      upd.kind_held          = kind;
      upd.first_was_point    = fwp;
      upd.first_was_zero     = fwz;
      upd.leading_zero_fault = lz;
      upd.point_seen         = ps;
      upd.earliest_fault     = fault;

      has_result = word.empty_token || word.last_char;
      if (word.empty_token) begin
         status = (word.token_kind == KIND_SIGN) ? ST_SIGN_LENGTH : ST_EMPTY;
      end else begin
         status = last_status;
      end
      state_in = has_result ? TOKEN_STATE_CLEAR : upd;
   end

endmodule

// File: src/token_spelling_checker.sv
// Top level of the token spelling checker: input register, token state, result register.
//
// The block checks one expression token at a time. Each request word carries one
// character with its token kind, a last-character mark and an empty-token flag;
// the kind counts only at the first character of a token. A response word with
// one status code is given for every word that is a last character or an empty
// token, and none for the other characters.
// A request word is taken into the input register at the edge where it is
// accepted; when it retires, its check completes against the token state and,
// if it closes a token, its status enters the result register, from which it
// is offered on the response channel.
// One request word can be accepted in every cycle while req ready is high; the
// rate is set by the single pass of character checking between the input and
// result registers. When the receiver stalls, a held result stays in the result
// register and the input register still takes a word; only a second closing
// word waits there, and then req ready falls until the response is taken.
// Synchronous reset empties both registers and clears the token state.
`timescale 1ns / 1ps

module token_spelling_checker (
   input logic     clock,
   input logic     reset,
   tsc_req_if.sink   req_port,
   tsc_rsp_if.source rsp_port
);
   import tsc_pkg::*;

   logic            word_valid_ff;
   logic            word_valid_in;
   req_word_type    word_ff;
   req_word_type    word_in;
   token_state_type state_ff;
   token_state_type state_in;
   token_state_type core_state;
   logic            has_result;
   logic [3:0]      core_status;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic [3:0]      status_ff;
   logic [3:0]      status_in;
   logic            advance;
   logic            req_take;

   tsc_core u_core (
      .word       (word_ff),
      .state      (state_ff),
      .state_in   (core_state),
      .has_result (has_result),
      .status     (core_status)
   );

   // The held word retires unless it needs the result register while that stays full.
   always_comb begin
      advance  = word_valid_ff &&
                 (!has_result || !rsp_valid_ff || rsp_port.ready);
      req_port.ready = !word_valid_ff || advance;
      req_take = req_port.valid && req_port.ready;

      word_in.token_kind  = req_port.token_kind;
      word_in.char_code   = req_port.char_code;
      word_in.last_char   = req_port.last_char;
      word_in.empty_token = req_port.empty_token;
      word_valid_in = req_take || (word_valid_ff && !advance);

      state_in = advance ? core_state : state_ff;

      rsp_valid_in = (advance && has_result) || (rsp_valid_ff && !rsp_port.ready);
      status_in    = (advance && has_result) ? core_status : status_ff;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= TOKEN_STATE_CLEAR;
      end else begin
         word_valid_ff <= word_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         state_ff      <= state_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         word_ff <= word_in;
      end
      status_ff <= status_in;
   end

   assign rsp_port.valid  = rsp_valid_ff;
   assign rsp_port.status = status_ff;

endmodule

// File: dv/tsc_status_board_pkg.sv
// Status predictor and status board for the token spelling checker testbench.
`timescale 1ns / 1ps

package tsc_status_board_pkg;
   import tsc_pkg::*;

   class tsc_status_board;
      // Token state as the checker should hold it between characters.
      logic [1:0] chars_in;
      logic [1:0] held_kind;
      logic       lead_point;
      logic       lead_zero;
      logic       zero_fault;
      logic       had_point;
      logic [3:0] first_fault;

      logic [3:0] status_q[$];
      int         error_count;
      int         checked_count;
      logic [15:0] seen_codes;

      function new();
         clear_token();
         error_count   = 0;
         checked_count = 0;
         seen_codes    = '0;
      endfunction

      function void clear_token();
         chars_in    = '0;
         held_kind   = KIND_NUMBER;
         lead_point  = 1'b0;
         lead_zero   = 1'b0;
         zero_fault  = 1'b0;
         had_point   = 1'b0;
         first_fault = ST_OK;
      endfunction

      function bit is_digit(logic [7:0] ch);
         return ch >= 8'h30 && ch <= 8'h39;
      endfunction

      // Letters and the underscore may open a word.
      function bit is_word_lead(logic [7:0] ch);
         return ch == CH_UNDERSCORE || (ch >= 8'h41 && ch <= 8'h5A) ||
                (ch >= 8'h61 && ch <= 8'h7A);
      endfunction

      function int pending();
         return status_q.size();
      endfunction

      // Update the token state with one accepted word and queue its status, if any.
      function void note_word(logic [1:0] kind_in, logic [7:0] ch, logic last,
                              logic empty);
         logic [1:0] kind;
         logic       lp;
         logic       lz;
         logic       zf;
         logic       hp;
         logic [3:0] fault;
         logic [3:0] status;

         // An empty token drops whatever token was in progress.
         if (empty) begin
            status_q.push_back(kind_in == KIND_SIGN ? ST_SIGN_LENGTH : ST_EMPTY);
            clear_token();
            return;
         end

         kind  = (chars_in == 0) ? kind_in : held_kind;
         lp    = (chars_in == 0) ? (ch == CH_POINT) : lead_point;
         lz    = (chars_in == 0) ? (ch == CH_ZERO) : lead_zero;
         zf    = zero_fault | (chars_in == 1 && lz && ch != CH_POINT);
         fault = first_fault;
         hp    = had_point;

         // Per-character checks; only the earliest fault is kept.
         case (kind)
            KIND_NUMBER: begin
               if (fault == ST_OK) begin
                  if (!is_digit(ch) && ch != CH_POINT)
                     fault = ST_NUM_SYMBOL;
                  else if (ch == CH_POINT && hp)
                     fault = ST_POINTS;
               end
               if (ch == CH_POINT)
                  hp = 1'b1;
            end
            KIND_WORD: begin
               if (chars_in == 0) begin
                  if (!is_word_lead(ch))
                     fault = ST_WORD_START;
               end else if (fault == ST_OK && !(is_digit(ch) || is_word_lead(ch))) begin
                  fault = ST_WORD_SYMBOL;
               end
            end
            KIND_SIGN: begin
               if (chars_in == 0 && (is_digit(ch) || is_word_lead(ch) || ch == CH_POINT))
                  fault = ST_SIGN_SYMBOL;
            end
            default: ;
         endcase

         // The last character closes the token with one status.
         if (last) begin
            case (kind)
               KIND_NUMBER: begin
                  if (lp || ch == CH_POINT)
                     status = ST_EDGE_POINT;
                  else if (zf)
                     status = ST_LEADING_ZERO;
                  else
                     status = fault;
               end
               KIND_WORD: status = fault;
               KIND_SIGN: status = (chars_in != 0) ? ST_SIGN_LENGTH : fault;
               default:   status = ST_EMPTY;
            endcase
            status_q.push_back(status);
            clear_token();
            return;
         end

         chars_in    = (chars_in < 2) ? chars_in + 2'd1 : 2'd2;
         held_kind   = kind;
         lead_point  = lp;
         lead_zero   = lz;
         zero_fault  = zf;
         had_point   = hp;
         first_fault = fault;
      endfunction

      // Compare one response word with the oldest expected status.
      function void check_status(logic [3:0] status);
         logic [3:0] want;

         checked_count++;
         seen_codes[status] = 1'b1;
         if (status_q.size() == 0) begin
            $error("status: expected none, actual %0d", status);
            error_count++;
            return;
         end
         want = status_q.pop_front();
         if (status !== want) begin
            $error("status: expected %0d, actual %0d", want, status);
            error_count++;
         end
      endfunction
   endclass

endpackage

// File: dv/tb_token_spelling_checker.sv
// Testbench top of the token spelling checker: stimulus, response monitor and run control.
`timescale 1ns / 1ps

module tb_token_spelling_checker;
   import tsc_pkg::*;
   import tsc_status_board_pkg::*;

   localparam int TOKEN_WORDS = 1500;
   localparam int CYCLE_LIMIT = 400000;

   logic clock;
   logic reset;
   int   cycle_count;
   int   words_sent;
   int   tokens_sent;
   int   burst_left;
   int   rsp_tick;
   logic [1:0] rsp_mode;
   string punct = "+-*/()<>=!&|^%~,;";

   tsc_status_board sb;

   tsc_req_if req_ch ();
   tsc_rsp_if rsp_ch ();

   token_spelling_checker dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch)
   );

   // Free-running clock.
   always #5 clock = ~clock;

   // Cycle counter for the run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Receiver stalls: one of four patterns, picked anew at random as rsp_tick runs on.
   always @(posedge clock) begin
      rsp_tick <= rsp_tick + 1;
      if (rsp_tick % 256 == 255)
         rsp_mode <= 2'($urandom_range(0, 3));
      case (rsp_mode)
         2'd0: rsp_ch.ready <= 1'b1;
         2'd1: rsp_ch.ready <= 1'($urandom_range(0, 1));
         2'd2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ch.ready <= (rsp_tick % 7) >= 3;
      endcase
   end

   // Every response word taken is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_status(rsp_ch.status);
   end

   // Send one request word; gaps between bursts fall before it.
   task automatic send_word(logic [1:0] kind, logic [7:0] ch, logic last, logic empty);
      int gap;

      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid       <= 1'b1;
      req_ch.token_kind  <= kind;
      req_ch.char_code   <= ch;
      req_ch.last_char   <= last;
      req_ch.empty_token <= empty;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_word(kind, ch, last, empty);
      words_sent++;
   endtask

   // Hold the sender off until every expected status has come back.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Send a whole token from text; the kind on later characters is noise.
   task automatic send_text(logic [1:0] kind, string text);
      for (int i = 0; i < text.len(); i++)
         send_word(i == 0 ? kind : 2'($urandom_range(0, 3)), text[i],
                   i == text.len() - 1, 1'b0);
      tokens_sent++;
   endtask

   function automatic logic [7:0] random_letter();
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] random_digit();
      return CH_ZERO + 8'($urandom_range(0, 9));
   endfunction

   // Pick a character that mostly fits the token kind, so faults stay rare enough
   // for the later checks to be reached.
   function automatic logic [7:0] random_char(logic [1:0] kind, int pos, int len,
                                              bit noisy);
      int roll;

      roll = $urandom_range(0, 99);
      if (noisy || roll < 3)
         return 8'($urandom_range(0, 255));
      case (kind)
         KIND_NUMBER: begin
            if (pos == 0) begin
               if (roll < 20) return CH_ZERO;
               if (roll < 28) return CH_POINT;
               return random_digit();
            end
            if (pos == len - 1 && roll < 10) return CH_POINT;
            if (roll < 16) return CH_POINT;
            if (roll < 20) return random_letter();
            return random_digit();
         end
         KIND_WORD: begin
            if (pos == 0) begin
               if (roll < 15) return random_digit();
               if (roll < 25) return CH_UNDERSCORE;
               return random_letter();
            end
            if (roll < 8) return punct[$urandom_range(0, punct.len() - 1)];
            if (roll < 30) return random_digit();
            if (roll < 40) return CH_UNDERSCORE;
            return random_letter();
         end
         KIND_SIGN: begin
            if (roll < 85) return punct[$urandom_range(0, punct.len() - 1)];
            if (roll < 90) return CH_POINT;
            return ($urandom_range(0, 1)) ? random_letter() : random_digit();
         end
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // One random token: well formed in most cases, with noise, lone empty tokens
   // and tokens cut short by an empty token.
   task automatic send_token();
      int         roll;
      int         len;
      int         cut;
      bit         noisy;
      bit         broken;
      logic [1:0] kind;

      roll = $urandom_range(0, 99);
      if (roll >= 95) begin
         send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 1'b1);
         tokens_sent++;
         return;
      end
      kind = (roll < 30) ? KIND_NUMBER : (roll < 60) ? KIND_WORD :
             (roll < 85) ? KIND_SIGN : KIND_UNKNOWN;
      if (kind == KIND_SIGN)
         len = ($urandom_range(0, 9) < 7) ? 1 : $urandom_range(2, 4);
      else
         len = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 5) : $urandom_range(6, 12);
      noisy  = ($urandom_range(0, 9) == 0);
      broken = ($urandom_range(0, 24) == 0);
      cut    = $urandom_range(0, len - 1);
      for (int i = 0; i < len; i++) begin
         if (broken && i == cut) begin
            send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 1'b1);
            break;
         end
         send_word(i == 0 ? kind : 2'($urandom_range(0, 3)),
                   random_char(kind, i, len, noisy), i == len - 1, 1'b0);
      end
      tokens_sent++;
   endtask

   // Reset, directed tokens, random tokens, then the final report.
   initial begin
      sb                 = new();
      clock              = 1'b0;
      reset              = 1'b1;
      cycle_count        = 0;
      words_sent         = 0;
      tokens_sent        = 0;
      burst_left         = 0;
      rsp_tick           = 0;
      rsp_mode           = 2'd0;
      req_ch.valid       = 1'b0;
      req_ch.token_kind  = KIND_NUMBER;
      req_ch.char_code   = '0;
      req_ch.last_char   = 1'b0;
      req_ch.empty_token = 1'b0;
      rsp_ch.ready       = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty tokens, the rules of each kind and a token dropped by an empty one.
      send_word(KIND_NUMBER, 8'hFF, 1'b1, 1'b1);
      send_word(KIND_SIGN, 8'h00, 1'b0, 1'b1);
      send_text(KIND_NUMBER, ".5");
      send_text(KIND_NUMBER, "05");
      send_text(KIND_NUMBER, "1..2");
      send_text(KIND_NUMBER, "1x");
      send_text(KIND_WORD, "_A9");
      send_text(KIND_WORD, "9a");
      send_word(KIND_WORD, 8'hFF, 1'b1, 1'b0);
      send_text(KIND_WORD, "a+");
      send_text(KIND_SIGN, "+");
      send_text(KIND_SIGN, "+-");
      send_text(KIND_SIGN, ".");
      send_text(KIND_UNKNOWN, "?");
      send_word(KIND_WORD, "a", 1'b0, 1'b0);
      send_word(KIND_WORD, 8'h00, 1'b1, 1'b1);
      drain_results();

      // Random tokens, with a full drain now and then.
      while (words_sent < TOKEN_WORDS) begin
         send_token();
         if (tokens_sent % 150 == 0)
            drain_results();
      end
      drain_results();
      repeat (4) @(posedge clock);

      $display("summary: %0d request words in %0d tokens, %0d status words checked",
               words_sent, tokens_sent, sb.checked_count);
      $display("summary: status codes observed (bit per code) = %b", sb.seen_codes[9:0]);
      if (sb.error_count == 0 && sb.pending() == 0)
         $display("tb_token_spelling_checker: done, clean");
      else
         $display("tb_token_spelling_checker: done, errors");
      $finish;
   end

   // Run limit: a hang ends the run as a failure.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb_token_spelling_checker: done, errors");
      $finish;
   end

endmodule
